// File: sv/assert_macros.svh
// Assertion helpers for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("implication check failed");

// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, ck, rs, expr) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(expr)) \
    else $error("forbidden condition seen");

`endif

// File: sv/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared widths, constants and the command type passed from the byte
// classifier to the result emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

  localparam int BYTE_W  = 8;
  localparam int CP_W    = 21;
  localparam int QCNT_W  = 3;
  localparam int CNT_W   = 2;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;

  localparam logic [CP_W-1:0] QMARK = CP_W'(8'h3F);

  // One accepted byte turns into qcount replacement marks followed by an
  // optional value item.
  typedef struct packed {
    logic [QCNT_W-1:0] qcount;
    logic              has_val;
    logic [CP_W-1:0]   value;
    logic              fin;
  } cmd_t;

endpackage

`default_nettype wire

// File: sv/utf8d_in_if.sv
// ----------------------------------------------------------------------------
// utf8d_in_if
// Byte channel: one byte of text and its end-of-text flag per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8d_in_if;
  logic                         valid;
  logic                         ready;
  logic [utf8d_pkg::BYTE_W-1:0] data_byte;
  logic                         final_byte;

  modport source (output valid, data_byte, final_byte, input ready);
  modport sink (input valid, data_byte, final_byte, output ready);
endinterface

`default_nettype wire

// File: sv/utf8d_out_if.sv
// ----------------------------------------------------------------------------
// utf8d_out_if
// Code point channel: one decoded code point per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8d_out_if;
  logic                       valid;
  logic                       ready;
  logic [utf8d_pkg::CP_W-1:0] code_point;
  logic                       end_of_text;

  modport source (output valid, code_point, end_of_text, input ready);
  modport sink (input valid, code_point, end_of_text, output ready);
endinterface

`default_nettype wire

// File: sv/utf8d_front.sv
// ----------------------------------------------------------------------------
// utf8d_front
// Accepts bytes, tracks the pending multibyte sequence and turns each byte
// that yields output into one command for the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_front (
  input  wire logic           clk,
  input  wire logic           rst,
  utf8d_in_if.sink            text,
  input  wire logic           full,
  output logic                push,
  output utf8d_pkg::cmd_t     cmd
);

  logic [utf8d_pkg::CP_W-1:0]   partial;
  logic [utf8d_pkg::CP_W-1:0]   partial_next;
  logic [utf8d_pkg::CNT_W-1:0]  expected;
  logic [utf8d_pkg::CNT_W-1:0]  expected_next;
  logic [utf8d_pkg::CNT_W-1:0]  taken;
  logic [utf8d_pkg::CNT_W-1:0]  taken_next;
  logic [utf8d_pkg::CP_W-1:0]   shifted;
  logic [utf8d_pkg::QCNT_W-1:0] qbase;
  logic [utf8d_pkg::BYTE_W-1:0] b;
  logic                         fin;
  logic                         lead_go;
  logic                         accept;

  assign text.ready = !full;
  assign accept     = text.valid && text.ready;
  assign push       = accept && ((cmd.qcount != '0) || cmd.has_val);

  always_comb begin
    b             = text.data_byte;
    fin           = text.final_byte;
    cmd           = '0;
    cmd.value     = utf8d_pkg::CP_W'(b);
    cmd.fin       = fin;
    partial_next  = partial;
    expected_next = expected;
    taken_next    = taken;
    lead_go       = 1'b1;
    qbase         = '0;
    shifted       = {partial[utf8d_pkg::CP_W-7:0], b[5:0]};

    if (expected != '0) begin
      if (b[7:6] == 2'b10) begin
        lead_go       = 1'b0;
        partial_next  = shifted;
        expected_next = expected - 2'd1;
        taken_next    = taken + 2'd1;
        if (expected == 2'd1) begin
          cmd.has_val   = 1'b1;
          cmd.value     = shifted;
          partial_next  = '0;
          taken_next    = '0;
        end else if (fin) begin
          cmd.qcount = 3'd2 + utf8d_pkg::QCNT_W'(taken);
        end
      end else begin
        qbase         = 3'd1 + utf8d_pkg::QCNT_W'(taken);
        partial_next  = '0;
        expected_next = '0;
        taken_next    = '0;
      end
    end

    if (lead_go) begin
      cmd.qcount = qbase;
      if (!b[7]) begin
        cmd.has_val = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        partial_next  = utf8d_pkg::CP_W'(b[4:0]);
        expected_next = 2'd1;
        taken_next    = '0;
      end else if (b[7:4] == 4'b1110) begin
        partial_next  = utf8d_pkg::CP_W'(b[3:0]);
        expected_next = 2'd2;
        taken_next    = '0;
      end else if (b[7:3] == 5'b11110) begin
        partial_next  = utf8d_pkg::CP_W'(b[2:0]);
        expected_next = 2'd3;
        taken_next    = '0;
      end else begin
        cmd.qcount = qbase + 3'd1;
      end
      if (fin && (expected_next != '0)) begin
        cmd.qcount = qbase + 3'd1;
      end
    end

    if (fin) begin
      partial_next  = '0;
      expected_next = '0;
      taken_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial  <= '0;
      expected <= '0;
      taken    <= '0;
    end else if (accept) begin
      partial  <= partial_next;
      expected <= expected_next;
      taken    <= taken_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/utf8d_queue.sv
// ----------------------------------------------------------------------------
// utf8d_queue
// Two-entry command queue between the classifier and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire utf8d_pkg::cmd_t  push_cmd,
  input  wire logic             pop,
  output utf8d_pkg::cmd_t       head,
  output logic                  empty,
  output logic                  full
);

  utf8d_pkg::cmd_t              slots [utf8d_pkg::QDEPTH];
  logic [utf8d_pkg::QPTR_W-1:0] wr_ptr;
  logic [utf8d_pkg::QPTR_W-1:0] rd_ptr;
  logic [utf8d_pkg::QPTR_W:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (utf8d_pkg::QPTR_W+1)'(utf8d_pkg::QDEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/utf8d_back.sv
// ----------------------------------------------------------------------------
// utf8d_back
// Expands each command into its result items, one per cycle while the
// receiver takes them, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire utf8d_pkg::cmd_t  head,
  input  wire logic             empty,
  output logic                  pop,
  utf8d_out_if.source           points
);

  logic                         ovalid;
  logic [utf8d_pkg::CP_W-1:0]   code_point;
  logic                         end_of_text;
  logic [utf8d_pkg::CNT_W-1:0]  idx;
  logic [utf8d_pkg::QCNT_W-1:0] total;
  logic [utf8d_pkg::QCNT_W-1:0] idx_ext;
  logic                         load;
  logic                         last;

  assign points.valid       = ovalid;
  assign points.code_point  = code_point;
  assign points.end_of_text = end_of_text;

  assign total   = head.qcount + utf8d_pkg::QCNT_W'(head.has_val);
  assign idx_ext = utf8d_pkg::QCNT_W'(idx);
  assign last    = ((idx_ext + 3'd1) == total);
  assign load    = !empty && (!ovalid || points.ready);
  assign pop     = load && last;

  always_ff @(posedge clk) begin
    if (load) begin
      code_point  <= (idx_ext < head.qcount) ? utf8d_pkg::QMARK : head.value;
      end_of_text <= last && head.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      idx    <= '0;
    end else begin
      if (load) begin
        ovalid <= 1'b1;
        idx    <= last ? '0 : idx + 2'd1;
      end else if (points.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/utf8_lenient_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_lenient_decoder_top
// Lenient UTF-8 decoder: bytes in, 21-bit code points out.
//
// The text channel takes one byte per item with final_byte set on the last
// byte of a text. The points channel gives one code point per item, with
// end_of_text set on the last item caused by a final byte. Bad, stray or
// truncated bytes come out as '?' marks.
// A byte is classified in the cycle it is accepted and its command is written
// into a two-entry queue; the emitter reads the queue head and registers each
// item in the output register.
// Bytes are taken at one per cycle while the queue is not full. A byte that
// causes k items holds the emitter until all k are out, so after a broken
// sequence the queue fills and text.ready drops until the replacement marks
// are out. When the receiver stalls, the output register holds its item and
// the queue fills, after which text.ready is low.
// Reset clears the pending sequence, the queue and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module utf8_lenient_decoder_top (
  input  wire logic   clk,
  input  wire logic   rst,
  utf8d_in_if.sink    text,
  utf8d_out_if.source points
);

  utf8d_pkg::cmd_t push_cmd;
  utf8d_pkg::cmd_t head;
  logic            push;
  logic            pop;
  logic            empty;
  logic            full;

  utf8d_front u_front (
    .clk  (clk),
    .rst  (rst),
    .text (text),
    .full (full),
    .push (push),
    .cmd  (push_cmd)
  );

  utf8d_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  utf8d_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .points (points)
  );

  `ASSERT_IMPLIES(a_final_pushes, clk, rst, text.valid && text.ready && text.final_byte, push)
  `ASSERT_NEVER(a_push_full, clk, rst, push && full)
  `ASSERT_NEVER(a_pop_empty, clk, rst, pop && empty)

endmodule

`default_nettype wire
